[rtl/fta_pkg.sv]
// Shared types and constants for the frame table allocator.
// No dependencies; used by fta_ctrl, fta_datapath and frame_table_allocator.
`default_nettype none
package fta_pkg;

  localparam int FRAMES = 4096;
  localparam int AW = $clog2(FRAMES);
  localparam int CW = AW + 1;
  localparam int PW = AW + 2;
  localparam logic [7:0] FREE_TAG = 8'h01;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_ALIGN = 2'd1;
  localparam logic [1:0] CMD_FREE  = 2'd2;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_BAD    = 2'd1;
  localparam logic [1:0] ST_NOROOM = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [12:0] frame_total;
    logic [12:0] align_frames;
    logic [7:0]  owner_tag;
    logic [11:0] first_frame;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] granted_frame;
    logic [12:0] free_frames;
  } rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_SC_RD, S_SC_EV, S_AL_SEEK, S_AL_CAND, S_AL_RD,
    S_AL_EV, S_CL_INIT, S_CLAIM, S_FR_RD, S_FR_EV, S_FIN
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_CLEAR, OP_LOAD, OP_SCAN_INIT, OP_SCAN_FREE, OP_SCAN_BUSY,
    OP_CAND_INIT, OP_CAND_STEP, OP_RUN_INIT, OP_RUN_FREE, OP_CLAIM_INIT,
    OP_CLAIM, OP_FREE_INIT, OP_FREE_STEP, OP_FINISH
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic bad_alloc;
    logic bad_free;
    logic short_cnt;
    logic is_free;
    logic pos_lt_n;
    logic pos_lt_end;
    logic len_hit;
    logic run_full;
    logic cand_lt_hint;
    logic cand_lt_n;
    logic clr_last;
    logic slot_free;
  } dp_flags_t;

endpackage
`default_nettype wire

[rtl/fta_datapath.sv]
// Datapath: frame tag memory, scan pointers, counters and result register.
// Depends on fta_pkg; driven by fta_ctrl commands.
`default_nettype none
module fta_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire fta_pkg::dp_cmd_t  cmd,
  output fta_pkg::dp_flags_t     flags,
  input  wire fta_pkg::req_t     req,
  input  wire logic [12:0]       n,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output fta_pkg::rsp_t          rsp
);

  logic [7:0]             mem [fta_pkg::FRAMES];
  logic [7:0]             rdata;
  fta_pkg::req_t          r;
  logic [fta_pkg::PW-1:0] pos;
  logic [fta_pkg::PW-1:0] cand;
  logic [fta_pkg::CW-1:0] runlen;
  logic [fta_pkg::AW-1:0] start;
  logic                   skipped;
  logic [fta_pkg::AW-1:0] hint;
  logic [fta_pkg::CW-1:0] freecnt;
  logic [fta_pkg::AW-1:0] clr;
  logic                   we;
  logic [fta_pkg::AW-1:0] wa;
  logic [7:0]             wd;
  logic [fta_pkg::PW-1:0] free_end;
  logic [fta_pkg::AW-1:0] hint_moved;

  always_comb begin
    we = 1'b0;
    wa = pos[fta_pkg::AW-1:0];
    wd = fta_pkg::FREE_TAG;
    case (cmd.op)
      fta_pkg::OP_CLEAR: begin
        we = 1'b1;
        wa = clr;
      end
      fta_pkg::OP_CLAIM: begin
        we = 1'b1;
        wd = r.owner_tag;
      end
      fta_pkg::OP_FREE_STEP: we = (rdata != fta_pkg::FREE_TAG);
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rdata <= mem[pos[fta_pkg::AW-1:0]];
  end

  assign free_end = fta_pkg::PW'(r.first_frame) + fta_pkg::PW'(r.frame_total);
  assign hint_moved = fta_pkg::AW'(fta_pkg::CW'(start) + r.frame_total);

  always_comb begin
    flags.cmd          = r.cmd;
    flags.bad_alloc    = (r.frame_total == '0) || r.owner_tag[0] ||
                         (r.owner_tag == fta_pkg::FREE_TAG) ||
                         ((r.cmd == fta_pkg::CMD_ALIGN) && (r.align_frames == '0));
    flags.bad_free     = (fta_pkg::CW'(r.first_frame) >= n) || (r.frame_total == '0);
    flags.short_cnt    = freecnt < r.frame_total;
    flags.is_free      = rdata == fta_pkg::FREE_TAG;
    flags.pos_lt_n     = pos < fta_pkg::PW'(n);
    flags.pos_lt_end   = (pos < free_end) && (pos < fta_pkg::PW'(n));
    flags.len_hit      = (runlen + 1'b1) == r.frame_total;
    flags.run_full     = runlen == r.frame_total;
    flags.cand_lt_hint = cand < fta_pkg::PW'(hint);
    flags.cand_lt_n    = cand < fta_pkg::PW'(n);
    flags.clr_last     = clr == fta_pkg::AW'(fta_pkg::FRAMES - 1);
    flags.slot_free    = !rsp_valid || rsp_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr       <= '0;
      hint      <= '0;
      freecnt   <= fta_pkg::CW'(fta_pkg::FRAMES);
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && (cmd.op != fta_pkg::OP_FINISH)) rsp_valid <= 1'b0;
      case (cmd.op)
        fta_pkg::OP_CLEAR: clr <= clr + 1'b1;
        fta_pkg::OP_LOAD: r <= req;
        fta_pkg::OP_SCAN_INIT: begin
          pos     <= fta_pkg::PW'(hint);
          runlen  <= '0;
          skipped <= 1'b0;
        end
        fta_pkg::OP_SCAN_FREE: begin
          if (runlen == '0) start <= pos[fta_pkg::AW-1:0];
          runlen <= runlen + 1'b1;
          pos    <= pos + 1'b1;
        end
        fta_pkg::OP_SCAN_BUSY: begin
          if (runlen != '0) skipped <= 1'b1;
          runlen <= '0;
          pos    <= pos + 1'b1;
        end
        fta_pkg::OP_CAND_INIT: cand <= '0;
        fta_pkg::OP_CAND_STEP: cand <= cand + fta_pkg::PW'(r.align_frames);
        fta_pkg::OP_RUN_INIT: begin
          pos    <= cand;
          start  <= cand[fta_pkg::AW-1:0];
          runlen <= '0;
        end
        fta_pkg::OP_RUN_FREE: begin
          runlen <= runlen + 1'b1;
          pos    <= pos + 1'b1;
        end
        fta_pkg::OP_CLAIM_INIT: begin
          pos    <= fta_pkg::PW'(start);
          runlen <= '0;
        end
        fta_pkg::OP_CLAIM: begin
          pos     <= pos + 1'b1;
          runlen  <= runlen + 1'b1;
          freecnt <= freecnt - 1'b1;
        end
        fta_pkg::OP_FREE_INIT: pos <= fta_pkg::PW'(r.first_frame);
        fta_pkg::OP_FREE_STEP: begin
          if (!flags.is_free) freecnt <= freecnt + 1'b1;
          pos <= pos + 1'b1;
        end
        fta_pkg::OP_FINISH: begin
          rsp_valid         <= 1'b1;
          rsp.status        <= cmd.status;
          rsp.free_frames   <= freecnt;
          rsp.granted_frame <= '0;
          if (cmd.status == fta_pkg::ST_DONE) begin
            if (r.cmd == fta_pkg::CMD_FREE) begin
              if (r.first_frame < hint) hint <= r.first_frame;
            end else begin
              rsp.granted_frame <= start;
              if ((r.cmd == fta_pkg::CMD_ALLOC) && !skipped) hint <= hint_moved;
            end
          end
        end
        default: clr <= clr;
      endcase
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    freecnt <= fta_pkg::CW'(fta_pkg::FRAMES))
    else $error("free count above frame total");
  a_claim_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.op == fta_pkg::OP_CLAIM |-> pos < fta_pkg::PW'(n))
    else $error("claim outside managed frames");
  a_grant_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == fta_pkg::OP_FINISH) && (cmd.status == fta_pkg::ST_DONE) &&
    (r.cmd != fta_pkg::CMD_FREE) |-> runlen == r.frame_total)
    else $error("grant without full claimed run");

endmodule
`default_nettype wire

[rtl/fta_ctrl.sv]
// Controller: sequences validation, scans, claims and frees over the datapath.
// Depends on fta_pkg; drives fta_datapath.
`default_nettype none
module fta_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire fta_pkg::dp_flags_t flags,
  output fta_pkg::dp_cmd_t        cmd
);

  fta_pkg::state_t state, state_next;
  logic [1:0]      res, res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fta_pkg::S_CLEAR;
      res   <= fta_pkg::ST_BAD;
    end else begin
      state <= state_next;
      res   <= res_next;
    end
  end

  always_comb begin
    state_next = state;
    res_next   = res;
    cmd.op     = fta_pkg::OP_NONE;
    cmd.status = res;
    req_ready  = 1'b0;
    case (state)
      fta_pkg::S_CLEAR: begin
        cmd.op = fta_pkg::OP_CLEAR;
        if (flags.clr_last) state_next = fta_pkg::S_IDLE;
      end
      fta_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.op     = fta_pkg::OP_LOAD;
          state_next = fta_pkg::S_CHECK;
        end
      end
      fta_pkg::S_CHECK: begin
        state_next = fta_pkg::S_FIN;
        res_next   = fta_pkg::ST_BAD;
        case (flags.cmd)
          fta_pkg::CMD_FREE: begin
            if (!flags.bad_free) begin
              cmd.op     = fta_pkg::OP_FREE_INIT;
              state_next = fta_pkg::S_FR_RD;
            end
          end
          fta_pkg::CMD_ALLOC, fta_pkg::CMD_ALIGN: begin
            if (flags.bad_alloc) begin
              res_next = fta_pkg::ST_BAD;
            end else if (flags.short_cnt) begin
              res_next = fta_pkg::ST_NOROOM;
            end else if (flags.cmd == fta_pkg::CMD_ALLOC) begin
              cmd.op     = fta_pkg::OP_SCAN_INIT;
              state_next = fta_pkg::S_SC_RD;
            end else begin
              cmd.op     = fta_pkg::OP_CAND_INIT;
              state_next = fta_pkg::S_AL_SEEK;
            end
          end
          default: res_next = fta_pkg::ST_BAD;
        endcase
      end
      fta_pkg::S_SC_RD: begin
        if (flags.pos_lt_n) begin
          state_next = fta_pkg::S_SC_EV;
        end else begin
          res_next   = fta_pkg::ST_NOROOM;
          state_next = fta_pkg::S_FIN;
        end
      end
      fta_pkg::S_SC_EV: begin
        if (flags.is_free) begin
          cmd.op     = fta_pkg::OP_SCAN_FREE;
          state_next = flags.len_hit ? fta_pkg::S_CL_INIT : fta_pkg::S_SC_RD;
        end else begin
          cmd.op     = fta_pkg::OP_SCAN_BUSY;
          state_next = fta_pkg::S_SC_RD;
        end
      end
      fta_pkg::S_AL_SEEK: begin
        if (flags.cand_lt_hint) cmd.op = fta_pkg::OP_CAND_STEP;
        else state_next = fta_pkg::S_AL_CAND;
      end
      fta_pkg::S_AL_CAND: begin
        if (flags.cand_lt_n) begin
          cmd.op     = fta_pkg::OP_RUN_INIT;
          state_next = fta_pkg::S_AL_RD;
        end else begin
          res_next   = fta_pkg::ST_NOROOM;
          state_next = fta_pkg::S_FIN;
        end
      end
      fta_pkg::S_AL_RD: begin
        if (flags.run_full) begin
          state_next = fta_pkg::S_CL_INIT;
        end else if (!flags.pos_lt_n) begin
          cmd.op     = fta_pkg::OP_CAND_STEP;
          state_next = fta_pkg::S_AL_CAND;
        end else begin
          state_next = fta_pkg::S_AL_EV;
        end
      end
      fta_pkg::S_AL_EV: begin
        if (flags.is_free) begin
          cmd.op     = fta_pkg::OP_RUN_FREE;
          state_next = fta_pkg::S_AL_RD;
        end else begin
          cmd.op     = fta_pkg::OP_CAND_STEP;
          state_next = fta_pkg::S_AL_CAND;
        end
      end
      fta_pkg::S_CL_INIT: begin
        cmd.op     = fta_pkg::OP_CLAIM_INIT;
        state_next = fta_pkg::S_CLAIM;
      end
      fta_pkg::S_CLAIM: begin
        if (flags.run_full) begin
          res_next   = fta_pkg::ST_DONE;
          state_next = fta_pkg::S_FIN;
        end else begin
          cmd.op = fta_pkg::OP_CLAIM;
        end
      end
      fta_pkg::S_FR_RD: begin
        if (flags.pos_lt_end) begin
          state_next = fta_pkg::S_FR_EV;
        end else begin
          res_next   = fta_pkg::ST_DONE;
          state_next = fta_pkg::S_FIN;
        end
      end
      fta_pkg::S_FR_EV: begin
        cmd.op     = fta_pkg::OP_FREE_STEP;
        state_next = fta_pkg::S_FR_RD;
      end
      fta_pkg::S_FIN: begin
        if (flags.slot_free) begin
          cmd.op     = fta_pkg::OP_FINISH;
          state_next = fta_pkg::S_IDLE;
        end
      end
      default: state_next = fta_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[rtl/frame_table_allocator.sv]
// Top level of the frame table allocator: APB register, controller, datapath.
// Depends on fta_pkg, fta_ctrl and fta_datapath.
`default_nettype none
// First-fit contiguous frame allocator over a 4096-entry tag memory, one byte
// per frame. After reset a clearing pass writes the free tag into every entry,
// one entry a cycle; no request word is taken until it ends. The tag memory has
// a registered read, so every frame examined is read, then evaluated. Allocate
// checks the request, scans from the search hint and then claims the run;
// aligned allocate steps through every alignment multiple below the hint and
// rescans each candidate run; free reads and evaluates each frame freed. Bad or
// oversized requests go straight from the check to the finish. The response
// word sits in an output register, so the next request is taken while it waits.
module frame_table_allocator (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire fta_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output fta_pkg::rsp_t      rsp,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [1:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [12:0]        frames_in_use;
  logic [12:0]        n;
  fta_pkg::dp_cmd_t   cmd;
  fta_pkg::dp_flags_t flags;

  // Single register, read and written at every address; paddr is ignored.
  assign pready = 1'b1;
  assign prdata = {19'd0, frames_in_use} | {30'd0, paddr & 2'b00};

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= 13'(fta_pkg::FRAMES);
    end else if (psel && penable && pwrite) begin
      frames_in_use <= pwdata[12:0];
    end
  end

  // Clamp the managed count to the table depth.
  assign n = (frames_in_use > 13'(fta_pkg::FRAMES)) ? 13'(fta_pkg::FRAMES) : frames_in_use;

  fta_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .flags     (flags),
    .cmd       (cmd)
  );

  fta_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .flags     (flags),
    .req       (req),
    .n         (n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire

[tb/sv/frame_table_allocator_tb.sv]
// Self-checking testbench for frame_table_allocator: directed, random and
// back-pressure tests against an in-bench predictor of the frame tag table.
// Depends on fta_pkg and the frame_table_allocator RTL.
module frame_table_allocator_tb;

  typedef struct {
    int start;
    int len;
  } run_t;

  logic          clk;
  logic          rst;
  logic          req_valid;
  logic          req_ready;
  fta_pkg::req_t req;
  logic          rsp_valid;
  logic          rsp_ready;
  fta_pkg::rsp_t rsp;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [1:0]    paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;

  // Predictor state: our own copy of the tag table, free count, hint and register.
  logic [7:0]  tag_mem [fta_pkg::FRAMES];
  int          free_cnt;
  int          hint;
  int          frames_reg;

  fta_pkg::rsp_t rsp_q[$];     // responses still owed by the block
  run_t          owned_q[$];   // runs granted and not yet freed
  bit            failed;
  int            tx_idle_pct;
  int            rx_stall_pct;
  int            hold_cycles;

  frame_table_allocator uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Length of the free run at start, capped at want and at the managed end.
  function automatic int free_run(int start, int want, int n);
    int k;
    k = 0;
    while (k < want && start + k < n && tag_mem[start + k] == fta_pkg::FREE_TAG) k++;
    return k;
  endfunction

  // Apply one request word to the table copy and return the response word.
  function automatic fta_pkg::rsp_t apply_request(fta_pkg::req_t r);
    fta_pkg::rsp_t o;
    int   n, cnt, al, i, k, stop;
    bit   move, bad;
    n = (frames_reg > fta_pkg::FRAMES) ? fta_pkg::FRAMES : frames_reg;
    cnt = r.frame_total;
    al = r.align_frames;
    o.status = fta_pkg::ST_BAD;
    o.granted_frame = '0;
    if (r.cmd == fta_pkg::CMD_ALLOC || r.cmd == fta_pkg::CMD_ALIGN) begin
      bad = cnt == 0 || r.owner_tag[0] || r.owner_tag == fta_pkg::FREE_TAG ||
            (r.cmd == fta_pkg::CMD_ALIGN && al == 0);
      if (bad) begin
        o.status = fta_pkg::ST_BAD;
      end else if (free_cnt < cnt) begin
        o.status = fta_pkg::ST_NOROOM;
      end else begin
        o.status = fta_pkg::ST_NOROOM;
        move = 1'b1;
        i = (r.cmd == fta_pkg::CMD_ALLOC) ? hint : ((hint + al - 1) / al) * al;
        while (i < n) begin
          if (tag_mem[i] == fta_pkg::FREE_TAG) begin
            k = free_run(i, cnt, n);
            if (k == cnt) begin
              for (int j = 0; j < cnt; j++) tag_mem[i + j] = r.owner_tag;
              free_cnt -= cnt;
              if (r.cmd == fta_pkg::CMD_ALLOC && move) hint = (i + cnt) % fta_pkg::FRAMES;
              o.granted_frame = i[11:0];
              o.status = fta_pkg::ST_DONE;
              owned_q.push_back('{i, cnt});
              break;
            end
            if (r.cmd == fta_pkg::CMD_ALLOC) begin
              i += k;
              move = 1'b0;
            end
          end
          i += (r.cmd == fta_pkg::CMD_ALLOC) ? 1 : al;
        end
      end
    end else if (r.cmd == fta_pkg::CMD_FREE) begin
      if (r.first_frame < n && cnt != 0) begin
        stop = r.first_frame + cnt;
        if (stop > n) stop = n;
        for (i = r.first_frame; i < stop; i++) begin
          if (tag_mem[i] != fta_pkg::FREE_TAG) begin
            tag_mem[i] = fta_pkg::FREE_TAG;
            free_cnt++;
          end
        end
        if (r.first_frame < hint) hint = r.first_frame;
        o.status = fta_pkg::ST_DONE;
      end
    end
    o.free_frames = free_cnt[12:0];
    return o;
  endfunction

  // Offer one word, hold it until taken, then predict and maybe go idle.
  task automatic send_word(fta_pkg::req_t r);
    bit taken;
    req <= r;
    req_valid <= 1'b1;
    do begin
      @(negedge clk);
      taken = req_ready;
      @(posedge clk);
    end while (!taken);
    rsp_q.push_back(apply_request(r));
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
  endtask

  function automatic fta_pkg::req_t make_word(logic [1:0] c, int total, int al, int tag,
                                               int first);
    fta_pkg::req_t r;
    r.cmd = c;
    r.frame_total = total[12:0];
    r.align_frames = al[12:0];
    r.owner_tag = tag[7:0];
    r.first_frame = first[11:0];
    return r;
  endfunction

  // Drop valid and wait until every owed response has come back.
  task automatic drain;
    req_valid <= 1'b0;
    while (rsp_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Register write through the APB port: setup cycle, then access cycle.
  task automatic write_frames(int value);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 2'd0;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    frames_reg = value & 32'h1FFF;
    @(posedge clk);
  endtask

  // Random word biased toward well-formed requests with small sizes.
  function automatic fta_pkg::req_t random_word(int big_pct);
    int   n, pick, total, al, tag, first, idx;
    n = (frames_reg > fta_pkg::FRAMES) ? fta_pkg::FRAMES : frames_reg;
    pick = $urandom_range(0, 99);
    total = ($urandom_range(0, 99) < big_pct) ? $urandom_range(0, 8191) :
            ($urandom_range(0, 3) == 0 ? $urandom_range(1, 24) : $urandom_range(1, 6));
    if ($urandom_range(0, 29) == 0) total = 0;
    al = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 16);
    tag = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 127) * 2;
    first = $urandom_range(0, 4095);
    if (pick < 40) return make_word(fta_pkg::CMD_ALLOC, total, al, tag, first);
    if (pick < 58) return make_word(fta_pkg::CMD_ALIGN, total, al, tag, first);
    if (pick < 95) begin
      // Mostly give back a granted run, otherwise free something arbitrary.
      if (owned_q.size() != 0 && $urandom_range(0, 3) != 0) begin
        idx = $urandom_range(0, owned_q.size() - 1);
        first = owned_q[idx].start;
        total = owned_q[idx].len;
        owned_q.delete(idx);
      end else if (n > 0 && $urandom_range(0, 3) != 0) begin
        first = $urandom_range(0, n - 1);
      end
      return make_word(fta_pkg::CMD_FREE, total, al, tag, first);
    end
    return make_word(2'd3, total, al, tag, first);
  endfunction

  task automatic test_directed;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    send_word(make_word(fta_pkg::CMD_ALLOC, 0, 0, 8'h02, 0));        // zero count
    send_word(make_word(fta_pkg::CMD_ALLOC, 4, 0, 8'h03, 0));        // odd tag
    send_word(make_word(fta_pkg::CMD_ALLOC, 4, 0, fta_pkg::FREE_TAG, 0)); // free tag
    send_word(make_word(fta_pkg::CMD_ALIGN, 4, 0, 8'h02, 0));        // zero alignment
    send_word(make_word(2'd3, 4, 4, 8'h02, 0));                      // unknown command
    send_word(make_word(fta_pkg::CMD_ALLOC, 8191, 1, 8'hFE, 0));     // over the free count
    send_word(make_word(fta_pkg::CMD_ALLOC, 3, 0, 8'hFE, 4095));
    send_word(make_word(fta_pkg::CMD_ALLOC, 2, 0, 8'h02, 0));
    send_word(make_word(fta_pkg::CMD_FREE, 1, 0, 8'h00, 0));         // hole, hint drops
    send_word(make_word(fta_pkg::CMD_ALLOC, 2, 0, 8'h04, 0));        // skips hole
    send_word(make_word(fta_pkg::CMD_ALIGN, 1, 4096, 8'h06, 0));     // aligned at zero only
    send_word(make_word(fta_pkg::CMD_ALIGN, 2, 8191, 8'h06, 0));
    send_word(make_word(fta_pkg::CMD_ALIGN, 5, 3, 8'hAA, 4095));
    send_word(make_word(fta_pkg::CMD_FREE, 0, 0, 8'h00, 0));         // zero-length free
    send_word(make_word(fta_pkg::CMD_FREE, 8191, 8191, 8'hFF, 4095));// cut off at the end
    send_word(make_word(fta_pkg::CMD_FREE, 4096, 0, 8'h00, 0));      // frees whole table
    send_word(make_word(fta_pkg::CMD_FREE, 4, 0, 8'h00, 0));         // already free frames
    send_word(make_word(fta_pkg::CMD_ALLOC, 4096, 0, 8'h10, 0));     // full run, hint wraps
    send_word(make_word(fta_pkg::CMD_ALLOC, 1, 0, 8'h10, 0));        // nothing left
    send_word(make_word(fta_pkg::CMD_FREE, 4096, 0, 8'h00, 0));
    owned_q.delete();
    write_frames(16);
    send_word(make_word(fta_pkg::CMD_ALLOC, 20, 0, 8'h20, 0));       // run passes the end
    send_word(make_word(fta_pkg::CMD_FREE, 2, 0, 8'h00, 20));        // first frame beyond n
    send_word(make_word(fta_pkg::CMD_ALLOC, 16, 0, 8'h20, 0));
    send_word(make_word(fta_pkg::CMD_ALLOC, 1, 0, 8'h20, 0));        // hint at n
    send_word(make_word(fta_pkg::CMD_FREE, 16, 0, 8'h00, 0));
    owned_q.delete();
  endtask

  task automatic test_random(int frames, int words, int tx_pct, int rx_pct, int big_pct);
    write_frames(frames);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (words) send_word(random_word(big_pct));
  endtask

  // Hold the receiver off while cheap words pile up, then pause to a full drain.
  task automatic test_backpressure;
    write_frames(64);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_cycles = 400;
    repeat (12) send_word(make_word(fta_pkg::CMD_ALLOC, 1, 0, 8'h08, 0));
    drain();
    repeat (12) send_word(make_word(fta_pkg::CMD_FREE, 1, 0, 8'h00, $urandom_range(0, 63)));
    owned_q.delete();
  endtask

  // Receiver: random stalls, with an optional long hold-off counted here.
  initial begin
    rsp_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= $urandom_range(0, 99) >= rx_stall_pct;
      end
    end
  end

  // Compare each taken response word with the oldest one owed.
  always @(negedge clk) begin
    fta_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (rsp_q.size() == 0) begin
        $error("response word with nothing outstanding: %h", rsp);
        failed = 1'b1;
      end else begin
        want = rsp_q.pop_front();
        if (rsp.status !== want.status) begin
          $error("status expected %0d got %0d", want.status, rsp.status);
          failed = 1'b1;
        end
        if (rsp.granted_frame !== want.granted_frame) begin
          $error("granted_frame expected %0d got %0d", want.granted_frame,
                 rsp.granted_frame);
          failed = 1'b1;
        end
        if (rsp.free_frames !== want.free_frames) begin
          $error("free_frames expected %0d got %0d", want.free_frames, rsp.free_frames);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    #2_000_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    failed = 1'b0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_cycles = 0;
    for (int i = 0; i < fta_pkg::FRAMES; i++) tag_mem[i] = fta_pkg::FREE_TAG;
    free_cnt = fta_pkg::FRAMES;
    hint = 0;
    frames_reg = fta_pkg::FRAMES;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(256, 200, 0, 0, 2);
    test_random(64, 200, 80, 0, 2);
    test_random(512, 150, 0, 80, 1);
    test_random(128, 200, 36, 36, 2);
    test_backpressure();
    test_random(4096, 100, 36, 36, 1);
    test_random(8191, 60, 0, 0, 1);     // clamps to the table size
    test_random(1, 60, 80, 0, 5);
    test_random(0, 30, 0, 80, 5);
    test_random(1000, 150, 0, 0, 1);
    test_random(32, 60, 36, 36, 3);

    drain();
    repeat (200) @(posedge clk);
    if (!failed) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/fta_pkg.sv
rtl/fta_datapath.sv
rtl/fta_ctrl.sv
rtl/frame_table_allocator.sv
tb/sv/frame_table_allocator_tb.sv
